// File: rtl/symmetric_envelope_lower_bound_defines.svh
// ----------------------------------------------------------------------------
// Symmetric envelope lower bound: assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef SYMMETRIC_ENVELOPE_LOWER_BOUND_DEFINES_SVH
`define SYMMETRIC_ENVELOPE_LOWER_BOUND_DEFINES_SVH

// Same-cycle implication, disabled while dis is true.
`define SELB_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while dis is true.
`define SELB_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/selb_pkg.sv
// ----------------------------------------------------------------------------
// selb_pkg
// Widths and limits shared by the symmetric envelope lower bound block.
// ----------------------------------------------------------------------------
package selb_pkg;

    localparam int VAL_W   = 16;           // signed Q4.12 sample
    localparam int DIFF_W  = VAL_W + 1;    // difference of two samples
    localparam int SQ_W    = 32;           // squared difference, Q8.24
    localparam int SUM_W   = 43;           // violation sum, Q.24
    localparam int LEN_W   = 7;            // segment length register
    localparam int BOUND_W = 48;           // final bound
    localparam int PROD_W  = LEN_W + SUM_W;

    localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(1);
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [BOUND_W-1:0] BOUND_MAX = {BOUND_W{1'b1}};

endpackage

// File: rtl/selb_term.sv
// ----------------------------------------------------------------------------
// selb_term
// Squared envelope violation of one value: select the violated edge, then
// square the distance. Two register stages, advanced together by en.
// ----------------------------------------------------------------------------
module selb_term (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [selb_pkg::VAL_W-1:0]  value,
    input  logic signed [selb_pkg::VAL_W-1:0]  upper,
    input  logic signed [selb_pkg::VAL_W-1:0]  lower,
    output logic        [selb_pkg::SQ_W-1:0]   sq
);
    import selb_pkg::*;

    logic signed [DIFF_W-1:0]   d_next;
    logic signed [DIFF_W-1:0]   d_reg;
    logic signed [2*DIFF_W-1:0] sq_full;
    logic        [SQ_W-1:0]     sq_reg;

    // Upper edge is tested first, also for an inverted envelope.
    always_comb begin
        if (upper < value) begin
            d_next = DIFF_W'(upper) - DIFF_W'(value);
        end else if (lower > value) begin
            d_next = DIFF_W'(lower) - DIFF_W'(value);
        end else begin
            d_next = '0;
        end
    end

    // |d| <= 2^16-1, so the square fits in SQ_W bits.
    assign sq_full = d_reg * d_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg  <= d_next;
            sq_reg <= sq_full[SQ_W-1:0];
        end
    end

    assign sq = sq_reg;

endmodule

// File: rtl/symmetric_envelope_lower_bound.sv
// ----------------------------------------------------------------------------
// symmetric_envelope_lower_bound
// Symmetric LB_Keogh on downsampled segments: two saturating sums of squared
// envelope violations, segment_len times the larger one per query/candidate pair.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Carries
// s_      | in        | s_valid / s_ready  | segment values, envelopes, last flag
// m_      | out       | m_valid / m_ready  | lower bound, saturated flag
// cfg_    | in        | cfg_we             | segment_len
//
// One item per cycle sustained while the output is not stalled. A pair's last item
// sets m_valid once it reaches the output register. Items move through a skid
// register, input register, edge select, square, accumulate, max, multiply and
// output register, all advancing together whenever the output register is free.
// s_ready is registered: it drops only while the skid register holds a request.
// Reset is synchronous: sums, flag and valid bits clear, segment_len goes to 1.
// ----------------------------------------------------------------------------
module symmetric_envelope_lower_bound (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic        [selb_pkg::LEN_W-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [selb_pkg::VAL_W-1:0]   s_query_value,
    input  logic signed [selb_pkg::VAL_W-1:0]   s_query_upper,
    input  logic signed [selb_pkg::VAL_W-1:0]   s_query_lower,
    input  logic signed [selb_pkg::VAL_W-1:0]   s_cand_value,
    input  logic signed [selb_pkg::VAL_W-1:0]   s_cand_upper,
    input  logic signed [selb_pkg::VAL_W-1:0]   s_cand_lower,
    input  logic                                s_last_segment,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [selb_pkg::BOUND_W-1:0] m_lower_bound,
    output logic                                m_saturated
);
    import selb_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] query_value;
        logic signed [VAL_W-1:0] query_upper;
        logic signed [VAL_W-1:0] query_lower;
        logic signed [VAL_W-1:0] cand_value;
        logic signed [VAL_W-1:0] cand_upper;
        logic signed [VAL_W-1:0] cand_lower;
        logic                    last_segment;
    } item_t;

    logic              adv;
    logic              s_accept;
    item_t             s_item;

    logic [LEN_W-1:0]  len_reg;

    logic              skid_valid_reg;
    item_t             skid_reg;
    logic              in_valid_reg;
    item_t             in_reg;

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic              last1_reg, last2_reg;

    logic [SQ_W-1:0]   sq_a;
    logic [SQ_W-1:0]   sq_b;

    logic [SUM_W-1:0]  sum_a_reg, sum_b_reg;
    logic              ovf_reg;
    logic [SUM_W:0]    add_a, add_b;
    logic [SUM_W-1:0]  sum_a_next, sum_b_next;
    logic              ovf_next;

    logic [SUM_W-1:0]  fin_a_reg, fin_b_reg;
    logic              fin_ovf_reg;
    logic [SUM_W-1:0]  mx_reg;
    logic              mx_ovf_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              prod_ovf_reg;

    logic              m_valid_reg;
    logic [BOUND_W-1:0] bound_reg;
    logic              sat_reg;

    // The whole pipe moves whenever the output register can take a new value.
    assign adv      = !m_valid_reg || m_ready;
    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;

    assign s_item = '{query_value:  s_query_value,
                      query_upper:  s_query_upper,
                      query_lower:  s_query_lower,
                      cand_value:   s_cand_value,
                      cand_upper:   s_cand_upper,
                      cand_lower:   s_cand_lower,
                      last_segment: s_last_segment};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= LEN_RESET;
        end else if (cfg_we) begin
            len_reg <= cfg_wdata;
        end
    end

    // Skid and input registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
        end else if (adv) begin
            if (skid_valid_reg) begin
                in_valid_reg   <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                in_valid_reg   <= s_accept;
            end
        end else if (s_accept) begin
            // Hold the request in the skid slot if the input register is busy.
            if (in_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                in_valid_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (skid_valid_reg) begin
                in_reg <= skid_reg;
            end else if (s_accept) begin
                in_reg <= s_item;
            end
        end else if (s_accept) begin
            if (in_valid_reg) begin
                skid_reg <= s_item;
            end else begin
                in_reg   <= s_item;
            end
        end
    end

    // Sum A: candidate value against the query envelope.
    selb_term u_term_a (
        .aclk  (aclk),
        .en    (adv),
        .value (in_reg.cand_value),
        .upper (in_reg.query_upper),
        .lower (in_reg.query_lower),
        .sq    (sq_a)
    );

    // Sum B: query value against the candidate envelope.
    selb_term u_term_b (
        .aclk  (aclk),
        .en    (adv),
        .value (in_reg.query_value),
        .upper (in_reg.cand_upper),
        .lower (in_reg.cand_lower),
        .sq    (sq_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && last2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last1_reg <= in_reg.last_segment;
            last2_reg <= last1_reg;
        end
    end

    // Saturating accumulate.
    assign add_a = {1'b0, sum_a_reg} + (SUM_W + 1)'(sq_a);
    assign add_b = {1'b0, sum_b_reg} + (SUM_W + 1)'(sq_b);

    always_comb begin
        ovf_next   = ovf_reg;
        sum_a_next = add_a[SUM_W-1:0];
        sum_b_next = add_b[SUM_W-1:0];
        if (add_a[SUM_W]) begin
            sum_a_next = SUM_MAX;
            ovf_next   = 1'b1;
        end
        if (add_b[SUM_W]) begin
            sum_b_next = SUM_MAX;
            ovf_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (adv && v2_reg) begin
            if (last2_reg) begin
                // Close the pair: clear for the next one.
                sum_a_reg <= '0;
                sum_b_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                sum_a_reg <= sum_a_next;
                sum_b_reg <= sum_b_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Final sums, max, product, output saturation.
    always_ff @(posedge aclk) begin
        if (adv) begin
            fin_a_reg    <= sum_a_next;
            fin_b_reg    <= sum_b_next;
            fin_ovf_reg  <= ovf_next;
            mx_reg       <= (fin_a_reg > fin_b_reg) ? fin_a_reg : fin_b_reg;
            mx_ovf_reg   <= fin_ovf_reg;
            prod_reg     <= PROD_W'(len_reg) * PROD_W'(mx_reg);
            prod_ovf_reg <= mx_ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (prod_reg[PROD_W-1:BOUND_W] != '0) begin
                bound_reg <= BOUND_MAX;
                sat_reg   <= 1'b1;
            end else begin
                bound_reg <= prod_reg[BOUND_W-1:0];
                sat_reg   <= prod_ovf_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_lower_bound = bound_reg;
    assign m_saturated   = sat_reg;

endmodule

// File: rtl/selb_checker.sv
// ----------------------------------------------------------------------------
// selb_checker
// Port-level checks for the symmetric envelope lower bound, bound to the top.
// ----------------------------------------------------------------------------
`include "symmetric_envelope_lower_bound_defines.svh"

module selb_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic        [selb_pkg::BOUND_W-1:0] m_lower_bound,
    input  logic                                m_saturated
);
    import selb_pkg::*;

    // A stalled result holds.
    `SELB_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready,
        m_valid && $stable(m_lower_bound) && $stable(m_saturated), "stalled result changed")

    // Reset empties the pipe and opens the input.
    `SELB_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn,
        !m_valid && s_ready, "pipe not empty after reset")

    // Ready drops only after a request is taken.
    `SELB_ASSERT_NEXT(a_ready_drop, aclk, !aresetn, s_ready && !s_valid,
        s_ready, "ready dropped without a request")

    // Once the output moves, the skid slot drains.
    `SELB_ASSERT_NEXT(a_skid_drain, aclk, !aresetn, !s_ready && (!m_valid || m_ready),
        s_ready, "skid slot did not drain")

endmodule

bind symmetric_envelope_lower_bound selb_checker u_selb_checker (.*);

// File: test/selb_bound_check_pkg.sv
// ----------------------------------------------------------------------------
// selb_bound_check_pkg
// Segment request and bound types plus a scoreboard that tracks both envelope
// violation sums, predicts each pair's bound and compares it with the block.
// ----------------------------------------------------------------------------
package selb_bound_check_pkg;

    timeunit 1ns;
    timeprecision 1ps;

    import selb_pkg::*;

    typedef struct {
        logic signed [VAL_W-1:0] query_value;
        logic signed [VAL_W-1:0] query_upper;
        logic signed [VAL_W-1:0] query_lower;
        logic signed [VAL_W-1:0] cand_value;
        logic signed [VAL_W-1:0] cand_upper;
        logic signed [VAL_W-1:0] cand_lower;
        logic                    last_segment;
    } segment_t;

    typedef struct {
        logic [BOUND_W-1:0] lower_bound;
        logic               saturated;
    } bound_t;

    class bound_scoreboard;
        logic [LEN_W-1:0] seg_len;
        logic [SUM_W-1:0] sum_cand_env;
        logic [SUM_W-1:0] sum_query_env;
        bit               overflow;
        bound_t           pending_bounds[$];
        int               errors;
        int               segments_noted;
        int               bounds_checked;

        function new();
            seg_len        = LEN_RESET;
            sum_cand_env   = '0;
            sum_query_env  = '0;
            overflow       = 1'b0;
            errors         = 0;
            segments_noted = 0;
            bounds_checked = 0;
        endfunction

        function void set_len(logic [LEN_W-1:0] v);
            seg_len = v;
        endfunction

        // Squared distance of v outside [lo, up]; the upper test wins on an
        // inverted envelope.
        function logic [SQ_W-1:0] outside_sq(logic signed [VAL_W-1:0] v,
                                             logic signed [VAL_W-1:0] up,
                                             logic signed [VAL_W-1:0] lo);
            logic signed [DIFF_W-1:0]   d;
            logic signed [2*DIFF_W-1:0] sq;
            if (up < v) begin
                d = {up[VAL_W-1], up} - {v[VAL_W-1], v};
            end else if (lo > v) begin
                d = {lo[VAL_W-1], lo} - {v[VAL_W-1], v};
            end else begin
                return '0;
            end
            sq = d * d;
            return sq[SQ_W-1:0];
        endfunction

        function logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] acc, logic [SQ_W-1:0] term);
            logic [SUM_W:0] s;
            s = {1'b0, acc} + (SUM_W+1)'(term);
            if (s > {1'b0, SUM_MAX}) begin
                overflow = 1'b1;
                return SUM_MAX;
            end
            return s[SUM_W-1:0];
        endfunction

        function void note_segment(segment_t seg);
            logic [SUM_W-1:0]  larger;
            logic [PROD_W-1:0] prod;
            bound_t            want;
            segments_noted++;
            sum_cand_env  = add_sat(sum_cand_env,
                                    outside_sq(seg.cand_value, seg.query_upper, seg.query_lower));
            sum_query_env = add_sat(sum_query_env,
                                    outside_sq(seg.query_value, seg.cand_upper, seg.cand_lower));
            if (!seg.last_segment) return;
            larger = (sum_cand_env > sum_query_env) ? sum_cand_env : sum_query_env;
            prod = PROD_W'(seg_len) * PROD_W'(larger);
            want.saturated = overflow;
            if (prod > PROD_W'(BOUND_MAX)) begin
                want.lower_bound = BOUND_MAX;
                want.saturated   = 1'b1;
            end else begin
                want.lower_bound = prod[BOUND_W-1:0];
            end
            pending_bounds = {pending_bounds, want};
            sum_cand_env  = '0;
            sum_query_env = '0;
            overflow      = 1'b0;
        endfunction

        function void check_bound(logic [BOUND_W-1:0] lb, logic sat);
            bound_t want;
            if (pending_bounds.size() == 0) begin
                errors++;
                $display("%0t: bound with nothing pending: expected none, actual %0d sat %0b",
                         $time, lb, sat);
                return;
            end
            want = pending_bounds.pop_front();
            bounds_checked++;
            if (lb !== want.lower_bound) begin
                errors++;
                $display("%0t: lower_bound mismatch: expected %0d, actual %0d",
                         $time, want.lower_bound, lb);
            end
            if (sat !== want.saturated) begin
                errors++;
                $display("%0t: saturated mismatch: expected %0b, actual %0b",
                         $time, want.saturated, sat);
            end
        endfunction
    endclass

endpackage

// File: test/symmetric_envelope_lower_bound_test.sv
// ----------------------------------------------------------------------------
// symmetric_envelope_lower_bound_test
// Drives segment requests with random gaps and output stalls, predicts every
// pair's bound in a scoreboard, and walks segment_len through 1, 0, 64, 127
// and random values: directed extremes, a long pair that saturates the
// product, random pairs.
// ----------------------------------------------------------------------------
module symmetric_envelope_lower_bound_test;

    timeunit 1ns;
    timeprecision 1ps;

    import selb_pkg::*;
    import selb_bound_check_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 16;
    localparam int PHASE_ITEMS  = 12;
    localparam int PHASES       = 6;
    localparam int SAT_RUN      = 520;

    logic                    aclk           = 1'b0;
    logic                    aresetn        = 1'b0;
    logic                    cfg_we         = 1'b0;
    logic [LEN_W-1:0]        cfg_wdata      = '0;
    logic                    s_valid        = 1'b0;
    logic                    s_ready;
    logic signed [VAL_W-1:0] s_query_value  = '0;
    logic signed [VAL_W-1:0] s_query_upper  = '0;
    logic signed [VAL_W-1:0] s_query_lower  = '0;
    logic signed [VAL_W-1:0] s_cand_value   = '0;
    logic signed [VAL_W-1:0] s_cand_upper   = '0;
    logic signed [VAL_W-1:0] s_cand_lower   = '0;
    logic                    s_last_segment = 1'b0;
    logic                    m_valid;
    logic                    m_ready        = 1'b0;
    logic [BOUND_W-1:0]      m_lower_bound;
    logic                    m_saturated;

    bound_scoreboard sb;
    int cycle_count  = 0;
    int len_writes   = 0;
    int input_calm   = 0;
    int output_calm  = 0;

    symmetric_envelope_lower_bound uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_query_value  (s_query_value),
        .s_query_upper  (s_query_upper),
        .s_query_lower  (s_query_lower),
        .s_cand_value   (s_cand_value),
        .s_cand_upper   (s_cand_upper),
        .s_cand_lower   (s_cand_lower),
        .s_last_segment (s_last_segment),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_lower_bound  (m_lower_bound),
        .m_saturated    (m_saturated)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Mostly a random idle gap, with occasional stretches of none.
    function automatic int draw_gap(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic segment_t make_seg(int qv, int qu, int ql, int cv, int cu, int cl,
                                          bit last);
        segment_t s;
        s.query_value  = VAL_W'(qv);
        s.query_upper  = VAL_W'(qu);
        s.query_lower  = VAL_W'(ql);
        s.cand_value   = VAL_W'(cv);
        s.cand_upper   = VAL_W'(cu);
        s.cand_lower   = VAL_W'(cl);
        s.last_segment = last;
        return s;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // Envelope around a random center with a value near it; tight puts the
    // value on or just past an edge, and now and then the envelope is inverted.
    function automatic void band(input bit tight,
                                 output logic signed [VAL_W-1:0] lo,
                                 output logic signed [VAL_W-1:0] up,
                                 output logic signed [VAL_W-1:0] v);
        int w;
        int centre;
        int lo_i;
        int up_i;
        int v_i;
        int t;
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 4096);
        centre = int'($urandom_range(0, 32767)) - 16384;
        lo_i = centre - w;
        up_i = centre + w;
        if (tight) begin
            case ($urandom_range(0, 3))
                0:       v_i = lo_i - 1;
                1:       v_i = lo_i;
                2:       v_i = up_i;
                default: v_i = up_i + 1;
            endcase
        end else begin
            v_i = centre + int'($urandom_range(0, 4 * w + 2)) - (2 * w + 1);
        end
        if ($urandom_range(0, 7) == 0) begin
            t = lo_i;
            lo_i = up_i;
            up_i = t;
        end
        lo = VAL_W'(lo_i);
        up = VAL_W'(up_i);
        v  = VAL_W'(v_i);
    endfunction

    function automatic segment_t random_seg(bit last);
        segment_t s;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            s.query_value = VAL_W'($urandom);
            s.query_upper = VAL_W'($urandom);
            s.query_lower = VAL_W'($urandom);
            s.cand_value  = VAL_W'($urandom);
            s.cand_upper  = VAL_W'($urandom);
            s.cand_lower  = VAL_W'($urandom);
        end else if (kind == 7) begin
            s.query_value = pick_extreme();
            s.query_upper = pick_extreme();
            s.query_lower = pick_extreme();
            s.cand_value  = pick_extreme();
            s.cand_upper  = pick_extreme();
            s.cand_lower  = pick_extreme();
        end else begin
            band(kind >= 8, s.query_lower, s.query_upper, s.cand_value);
            band(kind >= 8, s.cand_lower, s.cand_upper, s.query_value);
        end
        s.last_segment = last;
        return s;
    endfunction

    task automatic send_segment(segment_t seg);
        int gap;
        gap = draw_gap(input_calm);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_query_value  <= seg.query_value;
        s_query_upper  <= seg.query_upper;
        s_query_lower  <= seg.query_lower;
        s_cand_value   <= seg.cand_value;
        s_cand_upper   <= seg.cand_upper;
        s_cand_lower   <= seg.cand_lower;
        s_last_segment <= seg.last_segment;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_segment(seg);
    endtask

    // Send count copies of seg as one pair, the last carrying last_segment.
    task automatic send_run(segment_t seg, int count);
        for (int i = 0; i < count; i++) begin
            seg.last_segment = (i == count - 1);
            send_segment(seg);
        end
    endtask

    task automatic set_segment_len(logic [LEN_W-1:0] v);
        s_valid <= 1'b0;
        while (sb.pending_bounds.size() != 0) @(posedge aclk);
        // let any trailing non-last segments drain from the pipeline
        repeat (SETTLE) @(posedge aclk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_len(v);
        len_writes++;
    endtask

    task automatic receive_bounds();
        int stall;
        forever begin
            stall = draw_gap(output_calm);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_bound(m_lower_bound, m_saturated);
        end
    endtask

    task automatic random_phase(logic [LEN_W-1:0] len, int count);
        int left;
        bit last;
        left = 0;
        set_segment_len(len);
        for (int i = 0; i < count; i++) begin
            if (left == 0) begin
                left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 8);
            end
            last = (left == 1) || (i == count - 1);
            left = last ? 0 : left - 1;
            send_segment(random_seg(last));
        end
    endtask

    initial begin
        segment_t         worst;
        logic [LEN_W-1:0] len_plan [PHASES];

        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            receive_bounds();
        join_none

        // Reset length of 1: inside, both edges, extremes, inverted envelopes.
        send_segment(make_seg(0, 100, -100, 0, 100, -100, 1));
        send_segment(make_seg(-32768, -32768, -32768, 32767, 32767, 32767, 1));
        send_segment(make_seg(32767, 32767, 32767, 32767, 32767, 32767, 0));
        send_segment(make_seg(-32768, -32768, -32768, -32768, -32768, -32768, 1));
        send_segment(make_seg(-200, -100, 100, 0, -100, 100, 1));
        send_segment(make_seg(32767, -100, 100, 200, 0, 32767, 1));
        send_segment(make_seg(0, 10, -10, 50, 100, -100, 0));
        send_segment(make_seg(5, 10, -10, -40, 100, -100, 1));
        send_segment(make_seg(500, 100, -100, 0, 20, -20, 0));
        send_segment(make_seg(-500, 100, -100, 0, 20, -20, 1));
        send_segment(make_seg(100, 100, 100, -100, -100, -100, 1));
        send_segment(make_seg(101, 0, 0, -101, 0, 0, 0));
        send_segment(make_seg(0, -1, 1, 0, 32767, -32768, 0));
        send_segment(make_seg(-32768, 32767, -32768, 32767, -32768, 32767, 1));
        send_segment(make_seg(0, 0, 0, 0, 0, 0, 0));
        send_segment(make_seg(1, 0, 0, 0, 0, 0, 1));

        // Zero length forces a zero bound.
        worst = make_seg(-32768, -32768, -32768, 32767, 32767, 32767, 0);
        set_segment_len(LEN_W'(0));
        send_run(worst, 3);

        // Largest violations over a long pair push the product past the limit.
        set_segment_len(LEN_W'(127));
        send_run(worst, SAT_RUN);

        len_plan = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd0, 7'd0};
        len_plan[4] = LEN_W'($urandom_range(2, 63));
        len_plan[5] = LEN_W'($urandom_range(2, 63));
        for (int p = 0; p < PHASES; p++) begin
            random_phase(len_plan[p], PHASE_ITEMS);
        end

        s_valid <= 1'b0;
        while (sb.pending_bounds.size() != 0) @(posedge aclk);
        repeat (SETTLE + 4) @(posedge aclk);

        $display("covered %0d segments, %0d bounds checked, %0d segment_len writes",
                 sb.segments_noted, sb.bounds_checked, len_writes);
        $display("included envelope extremes, inverted envelopes and product saturation");
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
